// File: rtl/bae_pkg.sv
`default_nettype none

package bae_pkg;

  // field and state widths
  localparam int unsigned ProbW      = 12;
  localparam int unsigned RangeW     = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ProbShift  = 12;
  localparam int unsigned MaxBytes   = 4;

  // default depth of the input queue
  localparam int unsigned FifoDepthDef = 4;

  // reset values of the bounds
  localparam logic [RangeW-1:0] LowReset  = '0;
  localparam logic [RangeW-1:0] HighReset = '1;

  // one queued input item
  typedef struct packed {
    logic             coded_bit;
    logic [ProbW-1:0] prob_one;
  } item_t;

  // head of the input queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_UPD  = 4'b0100,
    S_EMIT = 4'b1000
  } back_state_e;

endpackage

`default_nettype wire

// File: rtl/bae_in_if.sv
`default_nettype none

interface bae_in_if;

  logic                      valid;
  logic                      ready;
  logic                      coded_bit;
  logic [bae_pkg::ProbW-1:0] prob_one;

  modport source (output valid, output coded_bit, output prob_one, input ready);
  modport sink   (input valid, input coded_bit, input prob_one, output ready);

endinterface

`default_nettype wire

// File: rtl/bae_out_if.sv
`default_nettype none

interface bae_out_if;

  logic                      valid;
  logic                      ready;
  logic [bae_pkg::ByteW-1:0] out_byte;
  logic                      last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);

endinterface

`default_nettype wire

// File: rtl/binary_arithmetic_encoder_top.sv
`default_nettype none

// Binary arithmetic encoder with 32-bit low and high bounds. Each input item
// carries a bit and its 12-bit probability of being one; the block narrows
// the interval and emits the zero to four leading bytes on which both bounds
// then agree, flagging the final byte of each item with last_of_run. Items
// with no settled byte produce no output. Items are handled one at a time by
// the back end sequencer, which pops an item, multiplies the range by the
// probability in a registered 20x12 multiplier, updates the bounds, then
// drains settled bytes one per cycle into the output register while that
// register is free; it pops the next item only after the last is done.
// An input queue of FifoDepth items lets the source run ahead meanwhile.
// After reset the bounds are 0x00000000 and 0xFFFFFFFF; no flush is done.
module binary_arithmetic_encoder_top #(
  parameter int unsigned FifoDepth = bae_pkg::FifoDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bae_in_if.sink    in_i,
  bae_out_if.source out_o
);

  import bae_pkg::*;

  head_t head;
  logic  pop;

  // input queue
  bae_front #(
    .FifoDepth (FifoDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // coding sequencer and output register
  bae_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/bae_front.sv
`default_nettype none

module bae_front #(
  parameter int unsigned FifoDepth = bae_pkg::FifoDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bae_in_if.sink         in_i,
  output bae_pkg::head_t head_o,
  input  wire logic      pop_i
);

  import bae_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  item_t            mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push;
  logic             pop;

  // handshake and head of queue
  assign in_i.ready        = (cnt_q != CntW'(FifoDepth));
  assign push              = in_i.valid && in_i.ready;
  assign head_o.valid      = (cnt_q != '0);
  assign head_o.item       = mem_q[rd_ptr_q];
  assign pop               = pop_i && head_o.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{coded_bit: in_i.coded_bit, prob_one: in_i.prob_one};
    end
  end

  // fill count stays within depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("queue fill count above depth");

  // a pop request only arrives with an item at the head
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/bae_back.sv
`default_nettype none

module bae_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bae_pkg::head_t  head_i,
  output logic                 pop_o,
  bae_out_if.source            out_o
);

  import bae_pkg::*;

  localparam int unsigned WidthW = RangeW - ProbShift;
  localparam int unsigned CntW   = $clog2(MaxBytes);

  back_state_e       st_q, st_d;
  logic [RangeW-1:0] lo_q, lo_d;
  logic [RangeW-1:0] hi_q, hi_d;
  logic [RangeW-1:0] diff_q, diff_d;
  logic [RangeW-1:0] prod_q, prod_d;
  logic              bit_q, bit_d;
  logic [ProbW-1:0]  prob_q, prob_d;
  logic [CntW-1:0]   n_q, n_d;
  logic              ov_q, ov_d;
  logic [ByteW-1:0]  ob_q, ob_d;
  logic              ol_q, ol_d;
  logic [WidthW-1:0] width_w;
  logic [RangeW-1:0] split;
  logic              agree;
  logic              agree_next;
  logic              slot_free;

  assign width_w    = diff_q[RangeW-1:ProbShift];
  assign split      = lo_q + prod_q;
  assign agree      = (lo_q[RangeW-1 -: ByteW] == hi_q[RangeW-1 -: ByteW]);
  assign agree_next = (lo_q[RangeW-ByteW-1 -: ByteW] == hi_q[RangeW-ByteW-1 -: ByteW]);
  assign slot_free  = !ov_q || out_o.ready;

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = ob_q;
  assign out_o.last_of_run = ol_q;

  // sequencer: pop, multiply, update bounds, drain settled bytes
  always_comb begin
    st_d   = st_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    diff_d = diff_q;
    prod_d = prod_q;
    bit_d  = bit_q;
    prob_d = prob_q;
    n_d    = n_q;
    ov_d   = ov_q && !out_o.ready;
    ob_d   = ob_q;
    ol_d   = ol_q;
    pop_o  = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          bit_d  = head_i.item.coded_bit;
          prob_d = head_i.item.prob_one;
          diff_d = hi_q - lo_q;
          st_d   = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = RangeW'(width_w * prob_q);
        st_d   = S_UPD;
      end
      S_UPD: begin
        if (bit_q) begin
          hi_d = split;
        end else begin
          lo_d = split + 1'b1;
        end
        n_d  = '0;
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (!agree) begin
          st_d = S_IDLE;
        end else if (slot_free) begin
          ov_d = 1'b1;
          ob_d = hi_q[RangeW-1 -: ByteW];
          ol_d = (n_q == CntW'(MaxBytes - 1)) || !agree_next;
          lo_d = {lo_q[RangeW-ByteW-1:0], {ByteW{1'b0}}};
          hi_d = {hi_q[RangeW-ByteW-1:0], {ByteW{1'b1}}};
          n_d  = n_q + 1'b1;
          if (ol_d) begin
            st_d = S_IDLE;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // control and bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      lo_q <= LowReset;
      hi_q <= HighReset;
      ov_q <= 1'b0;
      n_q  <= '0;
    end else begin
      st_q <= st_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      ov_q <= ov_d;
      n_q  <= n_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    prod_q <= prod_d;
    bit_q  <= bit_d;
    prob_q <= prob_d;
    ob_q   <= ob_d;
    ol_q   <= ol_d;
  end

  // the interval never inverts
  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("low bound above high bound");

  // bounds differ in the top byte whenever a new item starts
  a_top_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !agree)
    else $error("settled byte left undrained");

  // an item ends with a last marker when it emitted bytes
  a_last_on_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT && agree && slot_free && st_d == S_IDLE) |=> (ov_q && ol_q))
    else $error("run ended without last marker");

  // sequencer state stays one-hot
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q))
    else $error("sequencer state not one-hot");

endmodule

`default_nettype wire
